@@ rtl/cbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell balancing sequencer package
// Types, codes and constants shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package cbs_pkg;

	localparam int unsigned CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TARGET_VOLTAGE   = 3'd0,
		REG_END_DEVIATION    = 3'd1,
		REG_ON_TIME          = 3'd2,
		REG_REST_TIME        = 3'd3,
		REG_MEASURE_TIME     = 3'd4,
		REG_ACTION_REST_TIME = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_COMPLETE    = 3'd0,
		PH_ACTION_REST = 3'd1,
		PH_BALANCING   = 3'd2,
		PH_REST        = 3'd3,
		PH_MEASURE     = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SS_SELECT  = 2'd0,
		SS_ON_TIME = 2'd1,
		SS_STEADY  = 2'd2
	} substage_t;

	localparam logic [15:0] MIN_TARGET_MV    = 16'd3208;
	localparam logic [15:0] MAX_TARGET_MV    = 16'd3348;
	localparam logic [15:0] DEV_IN_BALANCING = 16'd5000;
	localparam logic [31:0] STEADY_MS        = 32'd500;
	localparam logic [31:0] REST_START_MS    = 32'd100;

	localparam logic [15:0] RST_TARGET_VOLTAGE   = 16'd5000;
	localparam logic [15:0] RST_END_DEVIATION    = 16'd5;
	localparam logic [31:0] RST_ON_TIME          = 32'd60000;
	localparam logic [31:0] RST_REST_TIME        = 32'd30000;
	localparam logic [31:0] RST_MEASURE_TIME     = 32'd30000;
	localparam logic [31:0] RST_ACTION_REST_TIME = 32'd500;

	typedef struct packed {
		logic [31:0] now_ms;
		logic [15:0] cell_max_mv;
	} tick_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [1:0] substage;
		logic       switch_cmd_valid;
		logic       switch_on;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_BITS-1:0] index;
		logic [31:0]             data;
	} cfg_write_t;

endpackage
`default_nettype wire

@@ rtl/cbs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell balancing sequencer channels
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface cbs_tick_if;
	logic          valid;
	logic          ready;
	cbs_pkg::tick_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cbs_result_if;
	logic            valid;
	logic            ready;
	cbs_pkg::result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cbs_cfg_if;
	logic               valid;
	logic               ready;
	cbs_pkg::cfg_write_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/cell_balancing_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cell balancing sequencer core
// Runs the timed balancing sequence, one result beat for each tick beat.
// ----------------------------------------------------------------------------
//  channel  dir  content
//  tick     in   now_ms, cell_max_mv
//  result   out  phase, substage, switch_cmd_valid, switch_on
//  cfg      in   register index, write data
//
//  A tick beat is registered in the tick register, evaluated against the
//  sequencer state and lands in the result register, so one beat is taken
//  each cycle while the result channel is not stalled. The tick register
//  lets a new tick enter while a result waits in the single result register.
//  A stalled result holds the tick register and the sequencer state.
//  Reset returns the sequencer to complete and the config registers to defaults.
// ----------------------------------------------------------------------------
module cell_balancing_sequencer_core #(
	parameter int unsigned TIME_BITS = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	cbs_tick_if.sink      tick,
	cbs_result_if.source  result,
	cbs_cfg_if.sink       cfg
);
	import cbs_pkg::*;

	localparam int unsigned EL_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

	logic [15:0] target_voltage_q;
	logic [15:0] end_deviation_q;
	logic [31:0] on_time_q;
	logic [31:0] rest_time_q;
	logic [31:0] measure_time_q;
	logic [31:0] action_rest_time_q;

	phase_t      phase_q, phase_d;
	substage_t   substage_q, substage_d;
	logic [31:0] mark_q, mark_d;
	logic        switch_q, switch_d;
	logic        cmd_d;

	logic        valid_s1;
	tick_t       tick_s1;
	logic        out_valid_q;
	result_t     out_q;
	logic        advance;

	logic [15:0]        vmax;
	logic [15:0]        target;
	logic [15:0]        dev;
	logic               needed;
	logic [31:0]        diff;
	logic [EL_BITS-1:0] el_trunc;
	logic [31:0]        el;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_voltage_q   <= RST_TARGET_VOLTAGE;
			end_deviation_q    <= RST_END_DEVIATION;
			on_time_q          <= RST_ON_TIME;
			rest_time_q        <= RST_REST_TIME;
			measure_time_q     <= RST_MEASURE_TIME;
			action_rest_time_q <= RST_ACTION_REST_TIME;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				REG_TARGET_VOLTAGE:   target_voltage_q   <= cfg.payload.data[15:0];
				REG_END_DEVIATION:    end_deviation_q    <= cfg.payload.data[15:0];
				REG_ON_TIME:          on_time_q          <= cfg.payload.data;
				REG_REST_TIME:        rest_time_q        <= cfg.payload.data;
				REG_MEASURE_TIME:     measure_time_q     <= cfg.payload.data;
				REG_ACTION_REST_TIME: action_rest_time_q <= cfg.payload.data;
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1 <= tick.payload;
		end
	end

	always_comb begin
		vmax = (tick_s1.cell_max_mv < MIN_TARGET_MV) ? MIN_TARGET_MV : tick_s1.cell_max_mv;
		if (target_voltage_q < MIN_TARGET_MV) begin
			target = MIN_TARGET_MV;
		end else if (target_voltage_q > MAX_TARGET_MV) begin
			target = MAX_TARGET_MV;
		end else begin
			target = target_voltage_q;
		end
		if (phase_q == PH_BALANCING) begin
			dev = DEV_IN_BALANCING;
		end else if (vmax > target) begin
			dev = vmax - target;
		end else begin
			dev = target - vmax;
		end
		needed   = (dev > end_deviation_q) && (vmax > target);
		diff     = tick_s1.now_ms - mark_q;
		el_trunc = diff[EL_BITS-1:0];
		el       = 32'(el_trunc);
	end

	always_comb begin
		phase_d    = phase_q;
		substage_d = substage_q;
		mark_d     = mark_q;
		switch_d   = switch_q;
		cmd_d      = 1'b0;
		if (needed) begin
			case (phase_q)
				PH_COMPLETE: begin
					mark_d  = tick_s1.now_ms;
					phase_d = PH_ACTION_REST;
				end
				PH_ACTION_REST: begin
					if (el >= action_rest_time_q) begin
						mark_d     = tick_s1.now_ms;
						substage_d = SS_SELECT;
						phase_d    = PH_BALANCING;
					end
				end
				PH_BALANCING: begin
					case (substage_q)
						SS_SELECT: begin
							switch_d   = 1'b1;
							cmd_d      = 1'b1;
							substage_d = SS_ON_TIME;
						end
						SS_ON_TIME: begin
							if (el >= on_time_q) begin
								switch_d   = 1'b0;
								cmd_d      = 1'b1;
								mark_d     = tick_s1.now_ms;
								substage_d = SS_STEADY;
							end
						end
						SS_STEADY: begin
							if (el >= STEADY_MS) begin
								mark_d  = tick_s1.now_ms;
								phase_d = PH_REST;
							end
						end
						default: ;
					endcase
				end
				PH_REST: begin
					if (el < REST_START_MS) begin
						substage_d = SS_SELECT;
					end
					if (el >= rest_time_q) begin
						mark_d  = tick_s1.now_ms;
						phase_d = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (el >= measure_time_q) begin
						mark_d  = tick_s1.now_ms;
						phase_d = PH_ACTION_REST;
					end
				end
				default: ;
			endcase
		end else begin
			phase_d = PH_COMPLETE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COMPLETE;
			substage_q <= SS_SELECT;
			mark_q     <= '0;
			switch_q   <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			substage_q <= substage_d;
			mark_q     <= mark_d;
			switch_q   <= switch_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.phase            <= phase_d;
			out_q.substage         <= substage_d;
			out_q.switch_cmd_valid <= cmd_d;
			out_q.switch_on        <= switch_d;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

`ifndef SYNTH
	a_cmd_in_balancing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.switch_cmd_valid) |-> (out_q.phase == PH_BALANCING))
		else $error("switch command outside balancing");

	a_switch_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.switch_on == switch_q))
		else $error("reported switch level differs from switch register");

	a_complete_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PH_COMPLETE)
			|=> (phase_q == PH_COMPLETE || phase_q == PH_ACTION_REST))
		else $error("complete left for a phase other than action rest");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready)
			|=> ($stable(phase_q) && $stable(mark_q) && $stable(switch_q)))
		else $error("sequencer state moved while the result was stalled");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell balancing sequencer testbench
// Sends timed ticks through the tick channel while the result channel stalls
// at random, and checks every result beat against a predictor of the phase,
// substage and switch sequence that runs on the accepted ticks and the
// register values written over the configuration channel.
// ----------------------------------------------------------------------------
module tb;
	import cbs_pkg::*;

	localparam int ITEM_GOAL = 1400;

	logic clk;
	logic arst_n;

	cbs_tick_if   tick_bus ();
	cbs_result_if result_bus ();
	cbs_cfg_if    cfg_bus ();

	cell_balancing_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// Register copies.
	logic [15:0] lim_target;
	logic [15:0] lim_end_dev;
	logic [31:0] dur_on;
	logic [31:0] dur_rest;
	logic [31:0] dur_measure;
	logic [31:0] dur_action_rest;

	// Sequencer state copies.
	phase_t      seq_phase;
	substage_t   seq_sub;
	logic [31:0] seq_mark;
	logic        seq_switch;

	result_t status_due[$];
	int      err_count;
	int      ticks_sent;
	int      gap_max;
	int      stall_max;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [15:0] clamp_target(input logic [15:0] v);
		if (v < MIN_TARGET_MV)
			return MIN_TARGET_MV;
		if (v > MAX_TARGET_MV)
			return MAX_TARGET_MV;
		return v;
	endfunction

	function automatic result_t advance_sequencer(input tick_t t);
		logic [15:0] vmax;
		logic [15:0] tgt;
		logic [15:0] dev;
		logic [31:0] el;
		logic        cmd;
		result_t     r;
		vmax = (t.cell_max_mv < MIN_TARGET_MV) ? MIN_TARGET_MV : t.cell_max_mv;
		tgt = clamp_target(lim_target);
		cmd = 1'b0;
		if (seq_phase == PH_BALANCING)
			dev = DEV_IN_BALANCING;
		else
			dev = (vmax > tgt) ? vmax - tgt : tgt - vmax;
		el = t.now_ms - seq_mark;
		if (dev > lim_end_dev && vmax > tgt) begin
			case (seq_phase)
				PH_COMPLETE: begin
					seq_mark = t.now_ms;
					seq_phase = PH_ACTION_REST;
				end
				PH_ACTION_REST: begin
					if (el >= dur_action_rest) begin
						seq_mark = t.now_ms;
						seq_sub = SS_SELECT;
						seq_phase = PH_BALANCING;
					end
				end
				PH_BALANCING: begin
					if (seq_sub == SS_SELECT) begin
						seq_switch = 1'b1;
						cmd = 1'b1;
						seq_sub = SS_ON_TIME;
					end else if (seq_sub == SS_ON_TIME) begin
						if (el >= dur_on) begin
							seq_switch = 1'b0;
							cmd = 1'b1;
							seq_mark = t.now_ms;
							seq_sub = SS_STEADY;
						end
					end else if (seq_sub == SS_STEADY) begin
						if (el >= STEADY_MS) begin
							seq_mark = t.now_ms;
							seq_phase = PH_REST;
						end
					end
				end
				PH_REST: begin
					if (el < REST_START_MS)
						seq_sub = SS_SELECT;
					if (el >= dur_rest) begin
						seq_mark = t.now_ms;
						seq_phase = PH_MEASURE;
					end
				end
				PH_MEASURE: begin
					if (el >= dur_measure) begin
						seq_mark = t.now_ms;
						seq_phase = PH_ACTION_REST;
					end
				end
				default: ;
			endcase
		end else begin
			seq_phase = PH_COMPLETE;
		end
		r.phase = seq_phase;
		r.substage = seq_sub;
		r.switch_cmd_valid = cmd;
		r.switch_on = seq_switch;
		return r;
	endfunction

	task automatic send_tick(input logic [31:0] now, input logic [15:0] mv);
		tick_t t;
		int    gap;
		t.now_ms = now;
		t.cell_max_mv = mv;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			@(negedge clk);
			tick_bus.valid <= 1'b0;
		end
		@(negedge clk);
		tick_bus.valid <= 1'b1;
		tick_bus.payload <= t;
		do
			@(posedge clk);
		while (!tick_bus.ready);
		status_due.push_back(advance_sequencer(t));
		ticks_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		tick_bus.valid <= 1'b0;
		wait (status_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
		cfg_write_t w;
		w.index = idx;
		w.data = data;
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.payload <= w;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_TARGET_VOLTAGE:   lim_target = data[15:0];
			REG_END_DEVIATION:    lim_end_dev = data[15:0];
			REG_ON_TIME:          dur_on = data;
			REG_REST_TIME:        dur_rest = data;
			REG_MEASURE_TIME:     dur_measure = data;
			REG_ACTION_REST_TIME: dur_action_rest = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [31:0] tgt, input logic [31:0] dev,
			input logic [31:0] on_ms, input logic [31:0] rest_ms,
			input logic [31:0] meas_ms, input logic [31:0] act_ms);
		drain_results();
		write_reg(REG_TARGET_VOLTAGE, tgt);
		write_reg(REG_END_DEVIATION, dev);
		write_reg(REG_ON_TIME, on_ms);
		write_reg(REG_REST_TIME, rest_ms);
		write_reg(REG_MEASURE_TIME, meas_ms);
		write_reg(REG_ACTION_REST_TIME, act_ms);
	endtask

	// Walks the whole sequence once under the reset register values.
	task automatic test_sequence_walk();
		logic [31:0] t0;
		logic [15:0] hi;
		hi = MAX_TARGET_MV + 16'd1;
		send_tick(32'h0000_0000, 16'h0000);
		send_tick(32'hFFFF_FFFF, 16'hFFFF);
		t0 = RST_ACTION_REST_TIME - 32'd1;
		send_tick(t0, 16'hFFFF);
		send_tick(t0, hi);
		send_tick(t0 + 32'd1, hi);
		t0 = t0 + RST_ON_TIME;
		send_tick(t0, hi);
		send_tick(t0 + STEADY_MS - 32'd1, hi);
		t0 = t0 + STEADY_MS;
		send_tick(t0, hi);
		send_tick(t0 + REST_START_MS / 2, MAX_TARGET_MV + RST_END_DEVIATION + 16'd1);
		t0 = t0 + RST_REST_TIME + 32'd7000;
		send_tick(t0, 16'hAAAA);
		send_tick(t0 + RST_MEASURE_TIME - 32'd1, 16'h5555);
		t0 = t0 + RST_MEASURE_TIME;
		send_tick(t0, 16'h5555);
		t0 = t0 + RST_ACTION_REST_TIME;
		send_tick(t0, hi);
		send_tick(t0, hi);
		send_tick(t0 + 32'd1, MAX_TARGET_MV);
		send_tick(t0 + 32'd2, MAX_TARGET_MV + RST_END_DEVIATION);
		send_tick(t0 + 32'd3, MAX_TARGET_MV + RST_END_DEVIATION + 16'd1);
		send_tick(32'hAAAA_AAAA, hi);
		send_tick(32'h5555_5555, hi);
		send_tick(32'h5555_5555, hi);
		send_tick(32'h5555_5556, MIN_TARGET_MV);
	endtask

	// Extreme register values, including the spare register indexes.
	task automatic test_register_extremes();
		logic [31:0] now;
		now = $urandom;
		write_all_regs(32'h0, 32'hFFFF, 32'h0, 32'h0, 32'h0, 32'h0);
		for (int i = int'(REG_ACTION_REST_TIME) + 1; i < (1 << CFG_IDX_BITS); i++)
			write_reg(i[CFG_IDX_BITS-1:0], $urandom);
		repeat (4) send_tick($urandom, 16'hFFFF);
		drain_results();
		write_reg(REG_END_DEVIATION, 32'h0);
		repeat (12) send_tick(now, MIN_TARGET_MV + 16'd1);
		send_tick(now, MIN_TARGET_MV);
		write_all_regs(32'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (14) begin
			send_tick(now, MAX_TARGET_MV + 16'd1);
			now = now + 32'hFFFF_FFFF;
		end
	endtask

	function automatic logic [31:0] pick_duration();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return $urandom;
			default: return $urandom_range(0, 1500);
		endcase
	endfunction

	// Random register settings, each followed by a run of well-formed ticks.
	task automatic test_random_sequences();
		logic [31:0] now;
		logic [15:0] tgt;
		logic [31:0] dev;
		int          mv;
		int          n;
		int          pause_at;
		bit          paused;
		paused = 1'b0;
		while (ticks_sent < ITEM_GOAL) begin
			tgt = ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: MIN_TARGET_MV + 16'($urandom_range(0, 140));
			dev = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 30);
			write_all_regs(tgt, dev, pick_duration(), pick_duration(),
				pick_duration(), pick_duration());
			if ($urandom_range(0, 3) == 0) begin
				gap_max = 0;
				stall_max = 0;
			end else begin
				gap_max = 5;
				stall_max = 5;
			end
			now = $urandom;
			n = $urandom_range(60, 120);
			pause_at = paused ? -1 : n / 2;
			for (int i = 0; i < n; i++) begin
				if (i == pause_at) begin
					drain_results();
					paused = 1'b1;
				end
				case ($urandom_range(0, 49))
					0: now = $urandom;
					1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: now = now + $urandom_range(0, 200);
					default: now = now + $urandom_range(0, 1600);
				endcase
				case ($urandom_range(0, 19))
					0: mv = $urandom_range(0, 65535);
					1: mv = int'(clamp_target(lim_target)) - $urandom_range(0, 20);
					default: mv = int'(clamp_target(lim_target)) + int'(lim_end_dev) + 1
						+ $urandom_range(0, 300);
				endcase
				if (mv > 65535)
					mv = 65535;
				send_tick(now, mv[15:0]);
			end
		end
		gap_max = 5;
		stall_max = 5;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (status_due.size() == 0) begin
				$error("result beat with no tick pending");
				err_count++;
			end else begin
				want = status_due.pop_front();
				if (result_bus.payload.phase !== want.phase) begin
					$error("phase: expected %0d, actual %0d", want.phase,
						result_bus.payload.phase);
					err_count++;
				end
				if (result_bus.payload.substage !== want.substage) begin
					$error("substage: expected %0d, actual %0d", want.substage,
						result_bus.payload.substage);
					err_count++;
				end
				if (result_bus.payload.switch_cmd_valid !== want.switch_cmd_valid) begin
					$error("switch_cmd_valid: expected %0d, actual %0d",
						want.switch_cmd_valid, result_bus.payload.switch_cmd_valid);
					err_count++;
				end
				if (result_bus.payload.switch_on !== want.switch_on) begin
					$error("switch_on: expected %0d, actual %0d", want.switch_on,
						result_bus.payload.switch_on);
					err_count++;
				end
			end
		end
	end

	initial begin : result_stalls
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, stall_max);
			repeat (stall) begin
				@(negedge clk);
				result_bus.ready <= 1'b0;
			end
			@(negedge clk);
			result_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_bus.valid);
		end
	end

	initial begin
		#5_000_000;
		$display("[cell_balancing_sequencer_core] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.payload = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.payload = '0;
		result_bus.ready = 1'b0;
		err_count = 0;
		ticks_sent = 0;
		gap_max = 5;
		stall_max = 5;
		lim_target = RST_TARGET_VOLTAGE;
		lim_end_dev = RST_END_DEVIATION;
		dur_on = RST_ON_TIME;
		dur_rest = RST_REST_TIME;
		dur_measure = RST_MEASURE_TIME;
		dur_action_rest = RST_ACTION_REST_TIME;
		seq_phase = PH_COMPLETE;
		seq_sub = SS_SELECT;
		seq_mark = '0;
		seq_switch = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_sequence_walk();
		test_register_extremes();
		test_random_sequences();

		drain_results();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("[cell_balancing_sequencer_core] OK");
		else
			$display("[cell_balancing_sequencer_core] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/cbs_pkg.sv
rtl/cbs_if.sv
rtl/cell_balancing_sequencer_core.sv
dv/tb.sv
